// File: hw/rtl/clb_pkg.sv
// Shared types and codes of the cursor line-edit buffer.
package clb_pkg;

  // Operation codes carried in the input item.
  typedef enum logic [2:0] {
    OP_LEFT      = 3'd0,
    OP_RIGHT     = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_INSERT    = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  // Status codes returned with every result item.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RANGE   = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam int unsigned CharW = 8;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned LenW  = 11;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    status_e           status;
    logic [LenW-1:0]   cursor_pos;
    logic [LenW-1:0]   text_length;
    logic [CharW-1:0]  read_char;
  } res_t;

endpackage

// File: hw/rtl/cursor_line_edit_buffer.sv
// Top level of the cursor line-edit buffer (gap buffer over two stack memories).
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       operation, new_char, read_index
//  m_axis    out        m_axis_tvalid/tready       read_char, text_length, cursor_pos, status
//
// Each item is first issued, which starts the stack-top or indexed read of a synchronous
// memory, and then completed, which takes its data, writes the other stack and forms the
// result. Reset (asynchronous, active low) empties both stacks by clearing the counts; the
// memories are not cleared. The result sits in an output register, so the next item is
// accepted while it waits; an item whose result cannot yet move into that register holds
// in its completion cycle.
module cursor_line_edit_buffer #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Bits [2:0] operation, [10:3] new_char, [20:11] read_index, [23:21] zero.
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Bits [7:0] read_char, [18:8] text_length, [29:19] cursor_pos, [31:30] status.
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  // Stack memory ports: "b" holds the text before the cursor, "a" the text
  // after it with the character next to the cursor on top.
  logic                       b_re, b_we, a_re, a_we;
  logic [AW-1:0]              b_raddr, b_waddr, a_raddr, a_waddr;
  logic [clb_pkg::CharW-1:0]  b_rdata, b_wdata, a_rdata, a_wdata;

  clb_pkg::res_t res, out_q;
  logic          res_valid, res_ready, out_valid_q;

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  clb_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tdata_i[2:0]),
    .ch_i       (s_axis_tdata_i[10:3]),
    .idx_i      (s_axis_tdata_i[20:11]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .b_re_o     (b_re),
    .b_raddr_o  (b_raddr),
    .b_rdata_i  (b_rdata),
    .b_we_o     (b_we),
    .b_waddr_o  (b_waddr),
    .b_wdata_o  (b_wdata),
    .a_re_o     (a_re),
    .a_raddr_o  (a_raddr),
    .a_rdata_i  (a_rdata),
    .a_we_o     (a_we),
    .a_waddr_o  (a_waddr),
    .a_wdata_o  (a_wdata)
  );

  clb_ram #(
    .Width(clb_pkg::CharW),
    .Depth(CAPACITY)
  ) u_before_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .re_i   (b_re),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  clb_ram #(
    .Width(clb_pkg::CharW),
    .Depth(CAPACITY)
  ) u_after_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // Output register holding one finished result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.status, out_q.cursor_pos, out_q.text_length,
                            out_q.read_char};

endmodule

// File: hw/rtl/clb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module clb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/clb_ctrl.sv
// Sequencer of the line-edit buffer: stack counters, memory accesses and results.
module clb_ctrl #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [clb_pkg::CharW-1:0]   ch_i,
  input  logic [clb_pkg::IdxW-1:0]    idx_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output clb_pkg::res_t               res_o,
  output logic                        b_re_o,
  output logic [$clog2(CAPACITY)-1:0] b_raddr_o,
  input  logic [clb_pkg::CharW-1:0]   b_rdata_i,
  output logic                        b_we_o,
  output logic [$clog2(CAPACITY)-1:0] b_waddr_o,
  output logic [clb_pkg::CharW-1:0]   b_wdata_o,
  output logic                        a_re_o,
  output logic [$clog2(CAPACITY)-1:0] a_raddr_o,
  input  logic [clb_pkg::CharW-1:0]   a_rdata_i,
  output logic                        a_we_o,
  output logic [$clog2(CAPACITY)-1:0] a_waddr_o,
  output logic [clb_pkg::CharW-1:0]   a_wdata_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > clb_pkg::IdxW) ? CW : clb_pkg::IdxW) + 1;

  clb_pkg::state_e state_q, state_d;
  logic [CW-1:0] bc_q, bc_d, ac_q, ac_d;
  logic [2:0] op_q;
  logic [clb_pkg::CharW-1:0] ch_q;
  clb_pkg::status_e stat_q, stat_d;
  logic sel_q, sel_d;

  logic [CW-1:0] bc_m1, ac_m1;
  logic [CW:0]   total;
  logic [XW-1:0] idx_x, bc_x, ac_x, off_x, apos_x, len_x, cur_x;
  logic [clb_pkg::CharW-1:0] rd_char;
  logic          accept, exec_fire;

  assign bc_m1  = bc_q - CW'(1);
  assign ac_m1  = ac_q - CW'(1);
  assign total  = {1'b0, bc_q} + {1'b0, ac_q};
  assign idx_x  = XW'(idx_i);
  assign bc_x   = XW'(bc_q);
  assign ac_x   = XW'(ac_q);
  assign off_x  = idx_x - bc_x;
  // The after stack keeps the character next to the cursor on top.
  assign apos_x = ac_x - XW'(1) - off_x;

  assign accept    = in_valid_i && in_ready_o;
  assign exec_fire = (state_q == clb_pkg::ST_EXEC) && res_ready_i;

  // Issue side: decide the status and start the single memory read.
  always_comb begin
    stat_d    = clb_pkg::STAT_DONE;
    sel_d     = 1'b0;
    b_re_o    = 1'b0;
    a_re_o    = 1'b0;
    b_raddr_o = bc_m1[AW-1:0];
    a_raddr_o = ac_m1[AW-1:0];
    case (op_i)
      clb_pkg::OP_LEFT: begin
        if (bc_q == '0 || ac_q >= CW'(CAPACITY)) begin
          stat_d = clb_pkg::STAT_IGNORED;
        end else begin
          b_re_o = accept;
        end
      end
      clb_pkg::OP_RIGHT: begin
        if (ac_q == '0 || bc_q >= CW'(CAPACITY)) begin
          stat_d = clb_pkg::STAT_IGNORED;
        end else begin
          a_re_o = accept;
        end
      end
      clb_pkg::OP_BACKSPACE: begin
        if (bc_q == '0) begin
          stat_d = clb_pkg::STAT_IGNORED;
        end
      end
      clb_pkg::OP_INSERT: begin
        if (total >= (CW+1)'(CAPACITY)) begin
          stat_d = clb_pkg::STAT_FULL;
        end
      end
      clb_pkg::OP_READ: begin
        if (idx_x < bc_x) begin
          b_re_o    = accept;
          b_raddr_o = idx_x[AW-1:0];
        end else if (off_x < ac_x) begin
          sel_d     = 1'b1;
          a_re_o    = accept;
          a_raddr_o = apos_x[AW-1:0];
        end else begin
          stat_d = clb_pkg::STAT_RANGE;
        end
      end
      default: stat_d = clb_pkg::STAT_IGNORED;
    endcase
  end

  // Completion side: write back, update the stack counts, form the result.
  always_comb begin
    state_d   = state_q;
    bc_d      = bc_q;
    ac_d      = ac_q;
    b_we_o    = 1'b0;
    a_we_o    = 1'b0;
    b_waddr_o = bc_q[AW-1:0];
    a_waddr_o = ac_q[AW-1:0];
    b_wdata_o = a_rdata_i;
    a_wdata_o = b_rdata_i;
    rd_char   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      clb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = clb_pkg::ST_EXEC;
        end
      end
      clb_pkg::ST_EXEC: begin
        res_valid_o = 1'b1;
        if (stat_q == clb_pkg::STAT_DONE) begin
          case (op_q)
            clb_pkg::OP_LEFT: begin
              a_we_o = exec_fire;
              bc_d   = bc_m1;
              ac_d   = ac_q + CW'(1);
            end
            clb_pkg::OP_RIGHT: begin
              b_we_o = exec_fire;
              ac_d   = ac_m1;
              bc_d   = bc_q + CW'(1);
            end
            clb_pkg::OP_BACKSPACE: bc_d = bc_m1;
            clb_pkg::OP_INSERT: begin
              b_we_o    = exec_fire;
              b_wdata_o = ch_q;
              bc_d      = bc_q + CW'(1);
            end
            clb_pkg::OP_READ: rd_char = sel_q ? a_rdata_i : b_rdata_i;
            default: ;
          endcase
        end
        if (res_ready_i) begin
          state_d = clb_pkg::ST_IDLE;
        end
      end
      default: state_d = clb_pkg::ST_IDLE;
    endcase
  end

  assign len_x             = XW'(bc_d) + XW'(ac_d);
  assign cur_x             = XW'(bc_d);
  assign res_o.read_char   = rd_char;
  assign res_o.text_length = len_x[clb_pkg::LenW-1:0];
  assign res_o.cursor_pos  = cur_x[clb_pkg::LenW-1:0];
  assign res_o.status      = stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clb_pkg::ST_IDLE;
      bc_q    <= '0;
      ac_q    <= '0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        bc_q <= bc_d;
        ac_q <= ac_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      ch_q   <= ch_i;
      stat_q <= stat_d;
      sel_q  <= sel_d;
    end
  end

  // The two stacks never hold more than the capacity together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CW+1)'(CAPACITY))
    else $error("stack counts exceed capacity");

  // Memory writes only complete an item, never overlap an issuing read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_we_o || a_we_o) |-> (state_q == clb_pkg::ST_EXEC && !b_re_o && !a_re_o))
    else $error("write outside completion cycle");

  // A stalled completion keeps the counts and the pending state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clb_pkg::ST_EXEC && !res_ready_i) |=>
      ($stable(bc_q) && $stable(ac_q) && state_q == clb_pkg::ST_EXEC))
    else $error("counts moved during stall");

  // Every accepted item reaches completion in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == clb_pkg::ST_EXEC))
    else $error("accepted item lost");

endmodule

// File: dv/tb_cursor_line_edit_buffer.sv
// Self-checking testbench of the cursor line-edit buffer, driven by directed and random edits.
module tb_cursor_line_edit_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity      = 1024;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainLimit    = 5000;
  localparam int unsigned FillGuard     = 4000;

  // Gap-buffer predictor plus the store of results still owed by the block.
  class edit_buffer_checker;
    localparam int unsigned Depth     = 1024;
    localparam int unsigned ShowLimit = 10;

    logic [7:0]     left_text[Depth];   // text before the cursor, in order
    logic [7:0]     right_text[Depth];  // text after the cursor, nearest on top
    int unsigned    n_left;
    int unsigned    n_right;
    clb_pkg::res_t  owed_results[$];
    int unsigned    bad_results;

    function new();
      n_left      = 0;
      n_right     = 0;
      bad_results = 0;
    endfunction

    function int unsigned text_len();
      return n_left + n_right;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    // Applies one accepted edit to the predicted text and queues its result.
    function void note_item(logic [23:0] item);
      logic [2:0]    op;
      logic [7:0]    ch;
      int unsigned   idx;
      clb_pkg::res_t r;
      op          = item[2:0];
      ch          = item[10:3];
      idx         = 32'(item[20:11]);
      r.read_char = '0;
      r.status    = clb_pkg::STAT_DONE;
      case (op)
        clb_pkg::OP_LEFT: begin
          if (n_left == 0 || n_right >= Depth) begin
            r.status = clb_pkg::STAT_IGNORED;
          end else begin
            n_left--;
            right_text[n_right] = left_text[n_left];
            n_right++;
          end
        end
        clb_pkg::OP_RIGHT: begin
          if (n_right == 0 || n_left >= Depth) begin
            r.status = clb_pkg::STAT_IGNORED;
          end else begin
            n_right--;
            left_text[n_left] = right_text[n_right];
            n_left++;
          end
        end
        clb_pkg::OP_BACKSPACE: begin
          if (n_left == 0) begin
            r.status = clb_pkg::STAT_IGNORED;
          end else begin
            n_left--;
          end
        end
        clb_pkg::OP_INSERT: begin
          if (n_left + n_right >= Depth) begin
            r.status = clb_pkg::STAT_FULL;
          end else begin
            left_text[n_left] = ch;
            n_left++;
          end
        end
        clb_pkg::OP_READ: begin
          if (idx < n_left) begin
            r.read_char = left_text[idx];
          end else if (idx - n_left < n_right) begin
            // Positions past the cursor count down from the top of the right stack.
            r.read_char = right_text[n_right - 1 - (idx - n_left)];
          end else begin
            r.status = clb_pkg::STAT_RANGE;
          end
        end
        default: begin
          r.status = clb_pkg::STAT_IGNORED;
        end
      endcase
      r.text_length = 11'(n_left + n_right);
      r.cursor_pos  = 11'(n_left);
      owed_results.insert(owed_results.size(), r);
    endfunction

    // Compares one delivered result with the oldest owed one.
    function void check_result(logic [31:0] data);
      clb_pkg::res_t got;
      clb_pkg::res_t want;
      got = clb_pkg::res_t'(data);
      if (owed_results.size() == 0) begin
        bad_results++;
        if (bad_results <= ShowLimit) begin
          $display("%0t: unexpected result %h with nothing owed", $realtime, data);
        end
        return;
      end
      want = owed_results.pop_front();
      if (got.read_char !== want.read_char || got.text_length !== want.text_length ||
          got.cursor_pos !== want.cursor_pos || got.status !== want.status) begin
        bad_results++;
        if (bad_results <= ShowLimit) begin
          $display({"%0t: result mismatch: char %h/%h length %0d/%0d",
                    " cursor %0d/%0d status %0d/%0d"},
                   $realtime, want.read_char, got.read_char, want.text_length,
                   got.text_length, want.cursor_pos, got.cursor_pos, want.status, got.status);
        end
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [23:0] in_data      = '0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_data;

  edit_buffer_checker edit_check = new();

  bit idle_on       = 1'b0;  // both sides insert gaps only while this is set
  bit hold_off_req  = 1'b0;  // asks the receiver for one long stall

  always #5 clk = ~clk;

  cursor_line_edit_buffer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  function automatic logic [23:0] pack_item(logic [2:0] op, logic [7:0] ch, logic [9:0] idx);
    return {3'b000, idx, ch, op};
  endfunction

  // Weights are percent; what is left over goes to the unused operation codes.
  function automatic logic [2:0] pick_op(int unsigned w_ins, int unsigned w_read,
                                         int unsigned w_left, int unsigned w_right,
                                         int unsigned w_bs);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return clb_pkg::OP_INSERT;
    r -= w_ins;
    if (r < w_read) return clb_pkg::OP_READ;
    r -= w_read;
    if (r < w_left) return clb_pkg::OP_LEFT;
    r -= w_left;
    if (r < w_right) return clb_pkg::OP_RIGHT;
    r -= w_right;
    if (r < w_bs) return clb_pkg::OP_BACKSPACE;
    return 3'(int'(clb_pkg::OP_READ) + $urandom_range(1, 3));
  endfunction

  // Reads land mostly inside the text, some just past its end, some anywhere.
  function automatic logic [9:0] pick_index(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (len == 0 || r < 2) return 10'($urandom_range(0, Capacity - 1));
    if (r < 3 && len < Capacity) return 10'(len);
    return 10'($urandom_range(0, len - 1));
  endfunction

  // Offers one item, holds it until accepted, then idles for a random gap.
  task automatic send_item(logic [23:0] item);
    int unsigned n;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    edit_check.note_item(item);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(int unsigned w_ins, int unsigned w_read, int unsigned w_left,
                             int unsigned w_right, int unsigned w_bs);
    logic [2:0] op;
    op = pick_op(w_ins, w_read, w_left, w_right, w_bs);
    send_item(pack_item(op, 8'($urandom_range(0, 255)), pick_index(edit_check.text_len())));
  endtask

  // Receiver: random ready pattern, plus one long stall when asked for it.
  initial begin : result_sink
    int unsigned left_cycles;
    int unsigned n;
    bit          held;
    left_cycles = 0;
    held        = 1'b0;
    forever begin
      @(posedge clk);
      if (left_cycles > 0) begin
        left_cycles--;
      end else if (hold_off_req && !held) begin
        held         = 1'b1;
        out_ready   <= 1'b0;
        left_cycles  = HoldOffCycles;
      end else begin
        n = gap_len();
        if (out_ready && n > 0) begin
          out_ready  <= 1'b0;
          left_cycles = n - 1;
        end else begin
          out_ready  <= 1'b1;
          left_cycles = $urandom_range(0, 20);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      edit_check.check_result(out_data);
    end
  end

  initial begin : stimulus
    int unsigned guard;
    int unsigned cyc;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edits on the empty buffer, all of which must be refused.
    send_item(pack_item(clb_pkg::OP_LEFT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_RIGHT, 8'hFF, 10'h3FF));
    send_item(pack_item(clb_pkg::OP_BACKSPACE, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'hFF, 10'h3FF));
    for (int k = int'(clb_pkg::OP_READ) + 1; k < 8; k++) begin
      send_item(pack_item(3'(k), 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023))));
    end
    // Short text with extreme byte values, then reads on both sides of the cursor.
    send_item(pack_item(clb_pkg::OP_INSERT, 8'h00, 10'h3FF));
    send_item(pack_item(clb_pkg::OP_INSERT, 8'hFF, 10'd0));
    send_item(pack_item(clb_pkg::OP_INSERT, 8'hA5, 10'd0));
    send_item(pack_item(clb_pkg::OP_INSERT, 8'h5A, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd3));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd4));
    send_item(pack_item(clb_pkg::OP_LEFT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_LEFT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd2));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd3));
    send_item(pack_item(clb_pkg::OP_INSERT, 8'h3C, 10'd0));
    send_item(pack_item(clb_pkg::OP_RIGHT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_BACKSPACE, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_RIGHT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_RIGHT, 8'h00, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd1));

    // Mixed edits on a short text: first back to back, then with idling.
    repeat (40) send_random(35, 25, 15, 12, 8);
    idle_on = 1'b1;
    repeat (80) send_random(35, 25, 15, 12, 8);

    // Grow the text to capacity; the receiver stalls at the start so the
    // block backs up while items keep coming.
    hold_off_req = 1'b1;
    guard = 0;
    while (edit_check.text_len() < Capacity && guard < FillGuard) begin
      send_random(85, 9, 2, 2, 2);
      guard++;
    end

    // Full buffer: a refused insert, reads at both ends, then random edits.
    send_item(pack_item(clb_pkg::OP_INSERT, 8'h7E, 10'd0));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'h3FF));
    send_item(pack_item(clb_pkg::OP_READ, 8'h00, 10'd0));
    repeat (60) send_random(30, 40, 12, 8, 8);

    in_valid <= 1'b0;
    for (cyc = 0; cyc < DrainLimit && edit_check.outstanding() != 0; cyc++) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (edit_check.bad_results == 0 && edit_check.outstanding() == 0) begin
      $display("tb_cursor_line_edit_buffer OK");
    end else begin
      $display("tb_cursor_line_edit_buffer NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_cursor_line_edit_buffer NOT OK");
    $finish;
  end

endmodule
